@@ src/htw_pkg.sv @@
// package for the hierarchical timer wheel core
// shared types, operation codes and default sizes; no dependencies
`default_nettype none
package htw_pkg;

  localparam int NUM_TIMERS_DEF = 32;
  localparam int SLOT_BITS_DEF  = 8;
  localparam int ID_W           = 5;
  localparam int TIME_W         = 32;

  typedef enum logic [1:0] {
    OP_TICK    = 2'd0,
    OP_START   = 2'd1,
    OP_RESTART = 2'd2,
    OP_STOP    = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CAS1,
    ST_CAS2,
    ST_EXP,
    ST_REPORT
  } state_t;

  typedef enum logic [2:0] {
    C_NONE,
    C_ARM,
    C_STOP,
    C_CAS,
    C_EXP
  } cell_op_t;

  typedef struct packed {
    cell_op_t   op;
    logic [1:0] level;
    logic       shift;
  } cell_cmd_t;

endpackage
`default_nettype wire

@@ src/htw_if.sv @@
// item channel interfaces for the timer wheel core
// depends on htw_pkg for field widths
`default_nettype none
interface htw_in_if;
  logic                        valid;
  logic                        ready;
  logic [1:0]                  operation;
  logic [htw_pkg::ID_W-1:0]    timer_id;
  logic [htw_pkg::TIME_W-1:0]  delay;
  logic [htw_pkg::TIME_W-1:0]  interval;
  modport source (output valid, operation, timer_id, delay, interval, input ready);
  modport sink (input valid, operation, timer_id, delay, interval, output ready);
endinterface

interface htw_out_if;
  logic                        valid;
  logic                        ready;
  logic [htw_pkg::ID_W-1:0]    expired_timer;
  logic                        rearmed;
  logic                        last_of_tick;
  modport source (output valid, expired_timer, rearmed, last_of_tick, input ready);
  modport sink (input valid, expired_timer, rearmed, last_of_tick, output ready);
endinterface
`default_nettype wire

@@ src/htw_cell.sv @@
// one timer of the pool: its schedule state and one stage of the report chain
// depends on htw_pkg
`default_nettype none
module htw_cell #(
  parameter int SLOT_BITS = htw_pkg::SLOT_BITS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire htw_pkg::cell_cmd_t            cmd,
  input  wire logic                          sel,
  input  wire logic [htw_pkg::TIME_W-1:0]    tick,
  input  wire logic [SLOT_BITS-1:0]          slot_idx,
  input  wire logic [htw_pkg::TIME_W-1:0]    arm_delay,
  input  wire logic [htw_pkg::TIME_W-1:0]    arm_period,
  input  wire logic                          nbr_due,
  input  wire logic                          nbr_rearm,
  output logic                               due_sr,
  output logic                               rearm_sr
);

  localparam int TW = htw_pkg::TIME_W;

  logic              armed;
  logic [TW-1:0]     expire;
  logic [TW-1:0]     period;
  logic [1:0]        level;
  logic [SLOT_BITS-1:0] slot;

  logic [TW-1:0]     pl_dly;
  logic [TW-1:0]     pl_epoch;
  logic [1:0]        pl_lvl;
  logic [SLOT_BITS-1:0] pl_slot;
  logic              hit;

  // delay the timer is placed with, by command
  always_comb begin
    case (cmd.op)
      htw_pkg::C_ARM: pl_dly = (arm_delay == '0) ? TW'(1) : arm_delay;
      htw_pkg::C_CAS: pl_dly = expire - tick;
      default:        pl_dly = period;
    endcase
  end

  // level by delay range, slot from expiry epoch at that level
  always_comb begin
    pl_epoch = tick + pl_dly;
    if ((pl_dly >> SLOT_BITS) == '0)           pl_lvl = 2'd0;
    else if ((pl_dly >> (2 * SLOT_BITS)) == '0) pl_lvl = 2'd1;
    else if ((pl_dly >> (3 * SLOT_BITS)) == '0) pl_lvl = 2'd2;
    else                                        pl_lvl = 2'd0;
    case (pl_lvl)
      2'd1:    pl_slot = SLOT_BITS'(pl_epoch >> SLOT_BITS);
      2'd2:    pl_slot = SLOT_BITS'(pl_epoch >> (2 * SLOT_BITS));
      default: pl_slot = SLOT_BITS'(pl_epoch);
    endcase
  end

  assign hit = armed && (level == cmd.level) && (slot == slot_idx);

  always_ff @(posedge clk) begin
    if (rst) begin
      armed    <= 1'b0;
      due_sr   <= 1'b0;
      rearm_sr <= 1'b0;
    end else begin
      case (cmd.op)
        htw_pkg::C_ARM: if (sel) begin
          period <= arm_period;
          expire <= pl_epoch;
          level  <= pl_lvl;
          slot   <= pl_slot;
          armed  <= 1'b1;
        end
        htw_pkg::C_STOP: if (sel) armed <= 1'b0;
        htw_pkg::C_CAS: if (hit) begin
          expire <= pl_epoch;
          level  <= pl_lvl;
          slot   <= pl_slot;
        end
        htw_pkg::C_EXP: begin
          due_sr   <= hit;
          rearm_sr <= (period != '0);
          if (hit) begin
            if (period != '0) begin
              expire <= pl_epoch;
              level  <= pl_lvl;
              slot   <= pl_slot;
            end else begin
              armed <= 1'b0;
            end
          end
        end
        default: ;
      endcase
      if (cmd.shift) begin
        due_sr   <= nbr_due;
        rearm_sr <= nbr_rearm;
      end
    end
  end

endmodule
`default_nettype wire

@@ src/hierarchical_timer_wheel_core.sv @@
// top level of the hierarchical timer wheel: sequencer, tick counter, cell row
// depends on htw_pkg, htw_if and htw_cell
//
//  channel  | dir | fields                                   | accepted when
//  ---------+-----+------------------------------------------+--------------
//  in_ch    | in  | operation, timer_id, delay, interval     | valid & ready
//  out_ch   | out | expired_timer, rearmed, last_of_tick     | valid & ready
//
// start, restart and stop are applied as they are accepted; in_ch is ready again the next cycle
// a tick runs the cascade states ST_CAS1 and ST_CAS2 when the lower levels wrap,
// then ST_EXP, then ST_REPORT, which reports up to the last due cell as the
// due bits shift down the cell row to the output register
// the report chain stalls while the output register holds an untaken item
// reset clears the counter, every armed bit and the output valid bit
`default_nettype none
module hierarchical_timer_wheel_core #(
  parameter int NUM_TIMERS = htw_pkg::NUM_TIMERS_DEF,
  parameter int SLOT_BITS  = htw_pkg::SLOT_BITS_DEF
) (
  input  wire logic   clk,
  input  wire logic   rst,
  htw_in_if.sink      in_ch,
  htw_out_if.source   out_ch
);

  localparam int TW = htw_pkg::TIME_W;
  localparam int IW = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;

  htw_pkg::state_t    state, state_next;
  htw_pkg::cell_cmd_t cmd;
  logic [TW-1:0]      tick_count;
  logic [TW-1:0]      tick_inc;
  logic [IW-1:0]      rep_idx;
  logic [SLOT_BITS-1:0] slot_idx;

  logic [NUM_TIMERS-1:0] due_v;
  logic [NUM_TIMERS-1:0] rearm_v;
  logic [NUM_TIMERS:0]   due_chain;
  logic [NUM_TIMERS:0]   rearm_chain;

  logic in_fire;
  logic is_tick;
  logic out_free;
  logic rest_due;
  logic any_due;

  assign in_ch.ready = (state == htw_pkg::ST_IDLE);
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign is_tick     = (in_ch.operation == htw_pkg::OP_TICK);
  assign tick_inc    = tick_count + TW'(1);
  assign out_free    = !out_ch.valid || out_ch.ready;

  // due bits of every cell above the head, and of the whole row
  assign rest_due = |(due_v >> 1);
  assign any_due  = |due_v;

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      htw_pkg::ST_IDLE:
        if (in_fire && is_tick) begin
          state_next = (SLOT_BITS'(tick_inc) == '0) ? htw_pkg::ST_CAS1 : htw_pkg::ST_EXP;
        end
      htw_pkg::ST_CAS1:
        state_next = (SLOT_BITS'(tick_count >> SLOT_BITS) == '0) ?
                     htw_pkg::ST_CAS2 : htw_pkg::ST_EXP;
      htw_pkg::ST_CAS2:
        state_next = htw_pkg::ST_EXP;
      htw_pkg::ST_EXP:
        state_next = htw_pkg::ST_REPORT;
      htw_pkg::ST_REPORT:
        // nothing is due, or the head item leaves and nothing is due behind it
        if (!any_due || (out_free && !rest_due)) state_next = htw_pkg::ST_IDLE;
      default:
        state_next = htw_pkg::ST_IDLE;
    endcase
  end

  // commands to the cell row
  always_comb begin
    cmd      = '{op: htw_pkg::C_NONE, level: 2'd0, shift: 1'b0};
    slot_idx = SLOT_BITS'(tick_count);
    unique case (state)
      htw_pkg::ST_IDLE:
        if (in_fire && !is_tick) begin
          cmd.op = (in_ch.operation == htw_pkg::OP_STOP) ? htw_pkg::C_STOP : htw_pkg::C_ARM;
        end
      htw_pkg::ST_CAS1: begin
        cmd.op    = htw_pkg::C_CAS;
        cmd.level = 2'd1;
        slot_idx  = SLOT_BITS'(tick_count >> SLOT_BITS);
      end
      htw_pkg::ST_CAS2: begin
        cmd.op    = htw_pkg::C_CAS;
        cmd.level = 2'd2;
        slot_idx  = SLOT_BITS'(tick_count >> (2 * SLOT_BITS));
      end
      htw_pkg::ST_EXP: begin
        cmd.op    = htw_pkg::C_EXP;
        cmd.level = 2'd0;
      end
      htw_pkg::ST_REPORT:
        cmd.shift = out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= htw_pkg::ST_IDLE;
      tick_count <= '0;
      rep_idx    <= '0;
    end else begin
      state <= state_next;
      if (in_fire && is_tick) tick_count <= tick_inc;
      if (state == htw_pkg::ST_EXP) rep_idx <= '0;
      else if (cmd.shift) rep_idx <= rep_idx + IW'(1);
    end
  end

  // output register, loaded from the head of the chain
  always_ff @(posedge clk) begin
    if (rst) begin
      out_ch.valid <= 1'b0;
    end else if (cmd.shift) begin
      out_ch.valid <= due_v[0];
    end else if (out_ch.ready) begin
      out_ch.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.shift && due_v[0]) begin
      out_ch.expired_timer <= htw_pkg::ID_W'(rep_idx);
      out_ch.rearmed       <= rearm_v[0];
      out_ch.last_of_tick  <= !rest_due;
    end
  end

  // row of cells; the report chain moves toward cell 0
  assign due_chain[NUM_TIMERS]   = 1'b0;
  assign rearm_chain[NUM_TIMERS] = 1'b0;

  for (genvar i = 0; i < NUM_TIMERS; i++) begin : g_cell
    logic sel;
    assign sel            = ({1'b0, in_ch.timer_id} == (htw_pkg::ID_W + 1)'(i));
    assign due_chain[i]   = due_v[i];
    assign rearm_chain[i] = rearm_v[i];

    htw_cell #(
      .SLOT_BITS (SLOT_BITS)
    ) u_cell (
      .clk        (clk),
      .rst        (rst),
      .cmd        (cmd),
      .sel        (sel),
      .tick       (tick_count),
      .slot_idx   (slot_idx),
      .arm_delay  (in_ch.delay),
      .arm_period (in_ch.interval),
      .nbr_due    (due_chain[i+1]),
      .nbr_rearm  (rearm_chain[i+1]),
      .due_sr     (due_v[i]),
      .rearm_sr   (rearm_v[i])
    );
  end

endmodule
`default_nettype wire

@@ src/htw_checker.sv @@
// port-level checks for the timer wheel core, bound to the top level
// depends on htw_pkg
`default_nettype none
module htw_checker (
  input wire logic                     clk,
  input wire logic                     rst,
  input wire logic                     in_valid,
  input wire logic                     in_ready,
  input wire logic [1:0]               in_operation,
  input wire logic                     out_valid,
  input wire logic                     out_ready,
  input wire logic [htw_pkg::ID_W-1:0] out_expired_timer
);

  logic in_fire;
  logic is_tick;
  assign in_fire = in_valid && in_ready;
  assign is_tick = (in_operation == htw_pkg::OP_TICK);

  // a stalled item holds its id
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_expired_timer))
    else $error("stalled item changed");

  // nothing comes out right after reset
  a_rst_quiet: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("item after reset");

  // arm and stop leave the input ready
  a_cmd_one: assert property (@(posedge clk) disable iff (rst)
    in_fire && !is_tick |=> in_ready)
    else $error("command held input");

  // a tick keeps the input closed while it runs
  a_tick_busy: assert property (@(posedge clk) disable iff (rst)
    in_fire && is_tick |=> !in_ready)
    else $error("tick accepted input too early");

endmodule

bind hierarchical_timer_wheel_core htw_checker u_htw_checker (
  .clk               (clk),
  .rst               (rst),
  .in_valid          (in_ch.valid),
  .in_ready          (in_ch.ready),
  .in_operation      (in_ch.operation),
  .out_valid         (out_ch.valid),
  .out_ready         (out_ch.ready),
  .out_expired_timer (out_ch.expired_timer)
);
`default_nettype wire

@@ tb/hierarchical_timer_wheel_core_tb.sv @@
// self-checking bench for the hierarchical timer wheel core
// depends on htw_pkg, htw_if and the core; drives arm, stop and tick items
// and compares every expiry item against an in-bench model of the wheel
`default_nettype none
module hierarchical_timer_wheel_core_tb;

  localparam int NT = 32;
  localparam int SB = 8;
  localparam int LIMIT = 2000000;

  logic clk = 1'b0;
  logic rst = 1'b1;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  htw_in_if  in_ch ();
  htw_out_if out_ch ();

  hierarchical_timer_wheel_core #(.NUM_TIMERS(NT), .SLOT_BITS(SB)) u_dut (
    .clk(clk), .rst(rst), .in_ch(in_ch.sink), .out_ch(out_ch.source)
  );

  typedef struct packed {
    logic [4:0] id;
    logic       rearm;
    logic       last;
  } expiry_t;

  typedef struct {
    htw_pkg::op_t op;
    logic [4:0]  id;
    logic [31:0] dly;
    logic [31:0] per;
    int          n_typed;   // -1: predictor only, else count of typed expiries
    expiry_t     typed;     // typed expiry when n_typed is 1
  } row_t;

  // wheel state of the predictor
  logic [31:0] now_tick;
  logic        armed_q [NT];
  logic [31:0] expire_q [NT];
  logic [31:0] period_q [NT];
  logic [1:0]  level_q [NT];
  logic [SB-1:0] slot_q [NT];

  expiry_t expiry_q [$];
  int errors = 0;
  int mismatches = 0;
  int n_items = 0;
  int n_expiries = 0;
  int n_pred = 0;
  int cycles = 0;
  logic quiet_in = 1'b0;
  logic quiet_out = 1'b0;

  function automatic logic [SB-1:0] wheel_idx(logic [31:0] t, int lvl);
    return SB'(t >> (lvl * SB));
  endfunction

  function automatic void place_timer(int id, logic [31:0] dly);
    logic [31:0] ep;
    int lvl;
    ep = now_tick + dly;
    if (dly < 32'd1 << SB) lvl = 0;
    else if (dly < 32'd1 << (2 * SB)) lvl = 1;
    else if (dly < 32'd1 << (3 * SB)) lvl = 2;
    else lvl = 0;
    expire_q[id] = ep;
    level_q[id] = 2'(lvl);
    slot_q[id] = wheel_idx(ep, lvl);
    armed_q[id] = 1'b1;
  endfunction

  function automatic void cascade_level(int lvl, logic [SB-1:0] s);
    logic due [NT];
    for (int i = 0; i < NT; i++)
      due[i] = armed_q[i] && level_q[i] == 2'(lvl) && slot_q[i] == s;
    for (int i = 0; i < NT; i++)
      if (due[i]) place_timer(i, expire_q[i] - now_tick);
  endfunction

  // applies one item to the model and queues the expiries it causes
  function automatic void wheel_apply(htw_pkg::op_t op, logic [4:0] id, logic [31:0] dly,
                                      logic [31:0] per);
    logic due [NT];
    logic [SB-1:0] s0, s1;
    int total, n;
    expiry_t e;
    total = 0;
    n = 0;
    case (op)
      htw_pkg::OP_TICK: begin
        now_tick = now_tick + 1;
        s0 = wheel_idx(now_tick, 0);
        if (s0 == 0) begin
          s1 = wheel_idx(now_tick, 1);
          cascade_level(1, s1);
          if (s1 == 0) cascade_level(2, wheel_idx(now_tick, 2));
        end
        for (int i = 0; i < NT; i++) begin
          due[i] = armed_q[i] && level_q[i] == 0 && slot_q[i] == s0;
          if (due[i]) total++;
        end
        for (int i = 0; i < NT; i++) begin
          if (due[i]) begin
            e.id = 5'(i);
            e.rearm = period_q[i] != 0;
            if (period_q[i] != 0) place_timer(i, period_q[i]);
            else armed_q[i] = 1'b0;
            n++;
            e.last = n == total;
            expiry_q.push_back(e);
            n_pred++;
          end
        end
      end
      htw_pkg::OP_STOP: armed_q[id] = 1'b0;
      default: begin
        period_q[id] = per;
        place_timer(id, dly == 0 ? 32'd1 : dly);
      end
    endcase
  endfunction

  // directed rows; typed expectations only where obvious
  row_t dir_rows [$];

  function automatic row_t mk(htw_pkg::op_t op, int id, logic [31:0] dly, logic [31:0] per,
                              int nt, expiry_t t);
    row_t r;
    r.op = op; r.id = 5'(id); r.dly = dly; r.per = per; r.n_typed = nt; r.typed = t;
    return r;
  endfunction

  task automatic send_item(htw_pkg::op_t op, logic [4:0] id, logic [31:0] dly,
                           logic [31:0] per);
    in_ch.valid <= 1'b1;
    in_ch.operation <= op;
    in_ch.timer_id <= id;
    in_ch.delay <= dly;
    in_ch.interval <= per;
    do @(posedge clk); while (!in_ch.ready);
    wheel_apply(op, id, dly, per);
    n_items++;
    if (!quiet_in && $urandom_range(99) < 30) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  endtask

  // sink side: random stall, checks each item against the oldest expectation
  always @(posedge clk) begin
    if (rst) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (expiry_q.size() == 0) begin
          errors++;
          if (mismatches++ < 10)
            $display("unexpected expiry id=%0d rearm=%0b last=%0b",
                     out_ch.expired_timer, out_ch.rearmed, out_ch.last_of_tick);
        end else begin
          expiry_t e;
          e = expiry_q.pop_front();
          n_expiries++;
          if (e.id !== out_ch.expired_timer || e.rearm !== out_ch.rearmed ||
              e.last !== out_ch.last_of_tick) begin
            errors++;
            if (mismatches++ < 10)
              $display("expiry mismatch: exp id=%0d rearm=%0b last=%0b got %0d %0b %0b",
                       e.id, e.rearm, e.last, out_ch.expired_timer, out_ch.rearmed,
                       out_ch.last_of_tick);
          end
        end
      end
      out_ch.ready <= quiet_out || $urandom_range(99) >= 30;
    end
  end

  // cycle limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    expiry_t none;
    expiry_t t0;
    logic [31:0] d;
    int id;
    int pick;
    none = '0;
    in_ch.valid = 1'b0;
    in_ch.operation = htw_pkg::OP_TICK;
    in_ch.timer_id = '0;
    in_ch.delay = '0;
    in_ch.interval = '0;
    out_ch.ready = 1'b0;
    now_tick = '0;
    for (int i = 0; i < NT; i++) begin
      armed_q[i] = 0; expire_q[i] = 0; period_q[i] = 0; level_q[i] = 0; slot_q[i] = 0;
    end

    // tick with nothing armed, zero delay as one, top id, periodic rearm,
    // stop of an idle timer, restart of an armed one, all-ones fields
    dir_rows.push_back(mk(htw_pkg::OP_TICK, 0, 0, 0, 0, none));
    dir_rows.push_back(mk(htw_pkg::OP_START, 31, 0, 0, -1, none));
    t0.id = 5'd31; t0.rearm = 1'b0; t0.last = 1'b1;
    dir_rows.push_back(mk(htw_pkg::OP_TICK, 0, 0, 0, 1, t0));
    dir_rows.push_back(mk(htw_pkg::OP_STOP, 7, 0, 0, -1, none));
    dir_rows.push_back(mk(htw_pkg::OP_START, 0, 1, 1, -1, none));
    dir_rows.push_back(mk(htw_pkg::OP_START, 1, 2, 0, -1, none));
    t0.id = 5'd0; t0.rearm = 1'b1; t0.last = 1'b1;
    dir_rows.push_back(mk(htw_pkg::OP_TICK, 0, 0, 0, 1, t0));
    dir_rows.push_back(mk(htw_pkg::OP_TICK, 31, '1, '1, -1, none));
    dir_rows.push_back(mk(htw_pkg::OP_STOP, 0, 0, 0, -1, none));
    dir_rows.push_back(mk(htw_pkg::OP_START, 2, 32'h0000_0100, 3, -1, none));
    dir_rows.push_back(mk(htw_pkg::OP_RESTART, 2, 32'h0001_0000, 0, -1, none));
    dir_rows.push_back(mk(htw_pkg::OP_START, 3, 32'h0100_0000, 0, -1, none));
    dir_rows.push_back(mk(htw_pkg::OP_START, 4, '1, '1, -1, none));
    dir_rows.push_back(mk(htw_pkg::OP_START, 5, 32'h00ff_ffff, 32'hffff_fffe, -1, none));
    dir_rows.push_back(mk(htw_pkg::OP_RESTART, 6, 5, 0, -1, none));
    dir_rows.push_back(mk(htw_pkg::OP_STOP, 31, 0, 0, -1, none));
    dir_rows.push_back(mk(htw_pkg::OP_START, 10, 4, 4, -1, none));
    dir_rows.push_back(mk(htw_pkg::OP_START, 11, 4, 0, -1, none));
    for (int k = 0; k < 5; k++) dir_rows.push_back(mk(htw_pkg::OP_TICK, 0, 0, 0, -1, none));

    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (dir_rows[r]) begin
      int before_n;
      before_n = n_pred;
      send_item(dir_rows[r].op, dir_rows[r].id, dir_rows[r].dly, dir_rows[r].per);
      if (dir_rows[r].n_typed >= 0) begin
        if (n_pred - before_n != dir_rows[r].n_typed ||
            (dir_rows[r].n_typed == 1 && expiry_q[$] != dir_rows[r].typed)) begin
          errors++;
          if (mismatches++ < 10) $display("directed row %0d disagrees with typed value", r);
        end
      end
    end

    // random part: mostly short delays and many ticks so expiries come often;
    // a quiet stretch in the middle runs both sides without idling
    for (int k = 0; k < 247; k++) begin
      quiet_in = k >= 100 && k < 150;
      quiet_out = quiet_in;
      pick = $urandom_range(99);
      id = $urandom_range(31);
      case ($urandom_range(9))
        0: d = $urandom();
        1: d = $urandom_range(256, 70000);
        default: d = $urandom_range(0, 12);
      endcase
      if (pick < 55)
        send_item(htw_pkg::OP_TICK, 5'($urandom), $urandom(), $urandom());
      else if (pick < 75)
        send_item(htw_pkg::OP_START, 5'(id), d,
                  $urandom_range(3) == 0 ? $urandom_range(1, 9) :
                  ($urandom_range(9) == 0 ? $urandom() : 32'd0));
      else if (pick < 88)
        send_item(htw_pkg::OP_RESTART, 5'(id), d, $urandom_range(1) ? 32'd0 : $urandom());
      else
        send_item(htw_pkg::OP_STOP, 5'(id), $urandom(), $urandom());
    end
    in_ch.valid <= 1'b0;
    quiet_in = 1'b0;
    quiet_out = 1'b0;

    while (expiry_q.size() != 0) @(posedge clk);
    repeat (NT + 20) @(posedge clk);

    $display("run: %0d items sent, %0d expiries checked, %0d mismatches",
             n_items, n_expiries, mismatches);
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end
endmodule
`default_nettype wire

@@ hierarchical_timer_wheel_core.f @@
src/htw_pkg.sv
src/htw_if.sv
src/htw_cell.sv
src/hierarchical_timer_wheel_core.sv
src/htw_checker.sv
tb/hierarchical_timer_wheel_core_tb.sv
